// ----- hdl/b2da_pkg.sv -----
`default_nettype none
// Package for the binary to decimal ASCII converter.
// Holds the digit cell control struct, the decimal base and the ASCII zero constant. No dependencies.
package b2da_pkg;

    localparam int unsigned DEC_BASE = 10;
    localparam logic [5:0] ASCII_ZERO = 6'h30;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ----- hdl/b2da_cell.sv -----
`default_nettype none
// One BCD digit cell of the converter chain: add-3 and bit shift during
// conversion, whole digit shift toward the top during leading zero skip and emission. Uses b2da_pkg.
module b2da_cell
    import b2da_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_bit,
    input  wire logic [3:0] i_digit,
    output logic            o_bit,
    output logic [3:0]      o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    assign adj     = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_bit   = adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.dabble) begin
            n_digit = {adj[2:0], i_bit};
        end else if (i_ctrl.move) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
`default_nettype wire

// ----- hdl/binary_to_decimal_ascii.sv -----
`default_nettype none
// Binary to decimal ASCII converter: a chain of BCD digit cells and its sequencer.
// Depends on b2da_pkg and b2da_cell.
//
// Usage: one transaction on the input channel (i_valid/o_ready, i_value) carries
// an unsigned number. The output channel (o_valid/i_ready) then gives one
// transaction per decimal digit, most significant first, leading zeros dropped,
// with the digit count and a flag on the final digit. A zero gives one '0'.
// The digit chain first shifts in all VALUE_WIDTH bits of the value with
// shift-and-add-3, one bit per cycle, then shifts each leading zero digit out
// of the top cell, makes a turnaround step, and emits the digits. Leading
// zeros and digits add up to NDIG for any value. The next item is accepted
// only after the last digit has left.
// Only one item is in work at a time; o_ready is high only while idle.
// A stalled receiver holds the current digit on the ports and freezes the chain.
// Reset returns the sequencer to idle; any item in work is dropped.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [5:0]                  o_digit_char,
    output logic [3:0]                  o_digit_count,
    output logic                        o_last_digit
);

    localparam int unsigned NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int unsigned DCW  = $clog2(NDIG + 1);
    localparam int unsigned BCW  = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [BCW-1:0]         r_bits;
    logic [DCW-1:0]         r_remain;
    logic [DCW-1:0]         r_count;

    t_cell_ctrl             ctrl;
    logic [NDIG-1:0]        cell_bit;
    logic [3:0]             cell_digit [NDIG];
    logic [3:0]             top_digit;
    logic                   in_xact;
    logic                   out_xact;
    logic                   skip_now;
    logic                   last_now;

    assign top_digit = cell_digit[NDIG-1];
    assign in_xact   = i_valid && o_ready;
    assign out_xact  = o_valid && i_ready;
    assign last_now  = (r_remain == DCW'(1));
    assign skip_now  = (r_state == S_SKIP) && (top_digit == 4'd0) && !last_now;

    always_comb begin
        ctrl.clear  = in_xact;
        ctrl.dabble = (r_state == S_CONV);
        ctrl.move   = skip_now || (out_xact && !last_now);
    end

    genvar g;
    generate
        for (g = 0; g < NDIG; g++) begin : g_cell
            logic       bit_in;
            logic [3:0] digit_in;
            if (g == 0) begin : g_first
                assign bit_in   = r_value[VALUE_WIDTH-1];
                assign digit_in = 4'd0;
            end else begin : g_rest
                assign bit_in   = cell_bit[g-1];
                assign digit_in = cell_digit[g-1];
            end
            b2da_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_bit   (bit_in),
                .i_digit (digit_in),
                .o_bit   (cell_bit[g]),
                .o_digit (cell_digit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        r_value  <= i_value;
                        r_bits   <= BCW'(VALUE_WIDTH);
                        r_remain <= DCW'(NDIG);
                        r_state  <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_value <= {r_value[VALUE_WIDTH-2:0], 1'b0};
                    r_bits  <= r_bits - BCW'(1);
                    if (r_bits == BCW'(1)) begin
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (skip_now) begin
                        r_remain <= r_remain - DCW'(1);
                    end else begin
                        r_count <= r_remain;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_xact) begin
                        if (last_now) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_remain <= r_remain - DCW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_EMIT);
    assign o_digit_char  = ASCII_ZERO + {2'b00, top_digit};
    assign o_digit_count = 4'(r_count);
    assign o_last_digit  = last_now;

endmodule
`default_nettype wire
